// ===== hw/rtl/vrg711_pkg.sv =====
// Shared types and constants for the voice record G.711 decoder.
// No dependencies; imported by vrg711_expand and voice_record_g711_decoder.
package vrg711_pkg;

   // companding law select, as held in the law_select register
   typedef enum logic [0:0] {
      LAW_A  = 1'b0,
      LAW_MU = 1'b1
   } law_type;

   typedef logic        [7:0]  code_type;
   typedef logic signed [15:0] pcm_type;

   // header layout
   localparam int HEADER_BYTES_DEF = 12;
   localparam int HDR_IDX_W        = 4;   // holds any header position up to 15
   localparam int LEN_W            = 32;  // payload length, little-endian in header

   // G.711 constants
   localparam logic [7:0] ALAW_XOR      = 8'h55;
   localparam logic [8:0] ALAW_SEG_BIAS = 9'h108;
   localparam logic [7:0] ULAW_BIAS     = 8'h84;

endpackage

// ===== hw/rtl/vrg711_expand.sv =====
// G.711 expander: one code byte to a 16-bit linear sample, A-law or mu-law.
// Depends on vrg711_pkg.
module vrg711_expand
   import vrg711_pkg::*;
(
   input  code_type code,
   input  law_type  law,
   output pcm_type  sample
);

   logic [7:0]  a_val;
   logic [2:0]  a_seg;
   logic [8:0]  a_base;
   logic [14:0] a_mag;
   pcm_type     a_sample;

   logic [7:0]  u_val;
   logic [7:0]  u_base;
   logic [14:0] u_mag;
   pcm_type     u_sample;

   // A-law: even bits inverted, sign set means positive
   always_comb begin
      a_val  = code ^ ALAW_XOR;
      a_seg  = a_val[6:4];
      a_base = {1'b0, a_val[3:0], 4'b0000} + ALAW_SEG_BIAS;
      priority if (a_seg == 3'd0) begin
         a_mag = {7'b0, a_val[3:0], 4'b1000};
      end else if (a_seg == 3'd1) begin
         a_mag = 15'(a_base);
      end else begin
         a_mag = 15'(a_base) << (a_seg - 3'd1);
      end
      a_sample = a_val[7] ? pcm_type'({1'b0, a_mag}) : -pcm_type'({1'b0, a_mag});
   end

   // mu-law: all bits inverted, biased magnitude
   always_comb begin
      u_val  = ~code;
      u_base = {1'b0, u_val[3:0], 3'b000} + ULAW_BIAS;
      u_mag  = 15'(u_base) << u_val[6:4];
      u_sample = u_val[7] ? pcm_type'({8'b0, ULAW_BIAS} - {1'b0, u_mag})
                          : pcm_type'({1'b0, u_mag} - {8'b0, ULAW_BIAS});
   end

   assign sample = (law == LAW_MU) ? u_sample : a_sample;

endmodule

// ===== hw/rtl/voice_record_g711_decoder.sv =====
// Top level of the voice record G.711 decoder: record parser, pipeline, ports.
// Depends on vrg711_pkg and vrg711_expand.
//
// Takes a byte stream of voice records, one byte per req transaction. Each
// record is HEADER_BYTES header bytes, the last four holding the payload length
// little-endian, then that many G.711 code bytes. Header bytes produce nothing;
// every payload byte produces one rsp transaction carrying a signed 16-bit
// linear sample, with rsp_tlast marking the record's final sample. A record of
// length zero yields no samples and the next byte starts a new header.
// csr_data selects the law (0 A-law, 1 mu-law); write it only while idle.
// Throughput is one byte per clock while rsp is not backpressured. The parser
// loads each accepted byte into the stage 1 input register, and the expander
// feeds the output register from it; rsp_tvalid and rsp_tdata come straight
// from that output register. Backpressure on rsp stalls both stages; an empty
// stage still takes a new byte while the output register waits.
module voice_record_g711_decoder
   import vrg711_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF   // 4..16
)(
   input  logic        clock,
   input  logic        reset,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,      // law_select
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] stream_byte
   // samples out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [15:0] pcm_sample
   output logic        rsp_tlast      // record_last
);

   localparam logic [HDR_IDX_W-1:0] LEN_FIRST = HDR_IDX_W'(HEADER_BYTES - 4);
   localparam logic [HDR_IDX_W-1:0] HDR_LAST  = HDR_IDX_W'(HEADER_BYTES - 1);
   localparam logic [HDR_IDX_W-1:0] HDR_STEP  = HDR_IDX_W'(1);
   localparam logic [LEN_W-1:0]     LEN_ONE   = LEN_W'(1);

   // ---- configuration ----
   law_type law_ff, law_in;

   // ---- record parser state ----
   logic                 in_payload_ff, in_payload_in;
   logic [HDR_IDX_W-1:0] header_index_ff, header_index_in;
   logic [LEN_W-1:0]     length_accum_ff, length_accum_in;
   logic [LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic [LEN_W-1:0]     accum_next;
   logic [1:0]           len_slot;

   // ---- stage 1: accepted payload byte ----
   logic     s1_valid_ff, s1_valid_in;
   code_type s1_code_ff;
   law_type  s1_law_ff;
   logic     s1_last_ff;

   // ---- stage 2: output register ----
   logic     rsp_valid_ff, rsp_valid_in;
   pcm_type  rsp_sample_ff;
   logic     rsp_last_ff;

   pcm_type  expand_sample;
   logic     req_fire;
   logic     s2_take;
   logic     s1_take;

   // config always accepted; the user must write it only while idle, the block does not enforce it
   assign csr_ready = 1'b1;
   assign law_in    = (csr_valid && csr_ready) ? law_type'(csr_data) : law_ff;

   // pipeline flow
   assign s2_take    = !rsp_valid_ff || rsp_tready;         // output reg can load
   assign s1_take    = !s1_valid_ff || s2_take;             // stage 1 can load
   assign req_tready = s1_take;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? in_payload_ff : (s1_valid_ff && !s2_take);
   assign rsp_valid_in = s2_take ? s1_valid_ff : rsp_valid_ff;

   // length byte lands at slot 0..3 of the 32-bit count
   assign len_slot   = 2'(header_index_ff - LEN_FIRST);
   assign accum_next = (header_index_ff >= LEN_FIRST)
                     ? (length_accum_ff | (LEN_W'(req_tdata) << {len_slot, 3'b000}))
                     : length_accum_ff;

   // parser next state
   always_comb begin
      in_payload_in   = in_payload_ff;
      header_index_in = header_index_ff;
      length_accum_in = length_accum_ff;
      bytes_left_in   = bytes_left_ff;
      if (req_fire) begin
         if (in_payload_ff) begin
            bytes_left_in = bytes_left_ff - LEN_ONE;
            if (bytes_left_ff == LEN_ONE) begin
               in_payload_in   = 1'b0;
               header_index_in = '0;
               length_accum_in = '0;
            end
         end else if (header_index_ff == HDR_LAST) begin
            // header complete; zero length skips straight to next header
            header_index_in = '0;
            length_accum_in = '0;
            if (accum_next != '0) begin
               in_payload_in = 1'b1;
               bytes_left_in = accum_next;
            end
         end else begin
            header_index_in = header_index_ff + HDR_STEP;
            length_accum_in = accum_next;
         end
      end
   end

   vrg711_expand u_expand (
      .code   (s1_code_ff),
      .law    (s1_law_ff),
      .sample (expand_sample)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff          <= LAW_A;
         in_payload_ff   <= 1'b0;
         header_index_ff <= '0;
         length_accum_ff <= '0;
         bytes_left_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         law_ff          <= law_in;
         in_payload_ff   <= in_payload_in;
         header_index_ff <= header_index_in;
         length_accum_ff <= length_accum_in;
         bytes_left_ff   <= bytes_left_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_code_ff <= req_tdata;
         s1_law_ff  <= law_ff;
         s1_last_ff <= (bytes_left_ff == LEN_ONE);
      end
      if (s2_take) begin
         rsp_sample_ff <= expand_sample;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---- checks ----
   // a header byte never enters the sample pipeline
   a_hdr_no_sample: assert property (@(posedge clock) disable iff (reset)
      req_fire && !in_payload_ff |=> !s1_valid_ff)
      else $error("header byte produced a sample");

   // payload mode always has bytes outstanding
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (bytes_left_ff != '0))
      else $error("payload mode with zero bytes left");

   // header position stays inside the header
   a_hdr_index: assert property (@(posedge clock) disable iff (reset)
      header_index_ff <= HDR_LAST)
      else $error("header index out of range");

   // the record's final byte returns the parser to header mode
   a_last_ends_record: assert property (@(posedge clock) disable iff (reset)
      req_fire && in_payload_ff && (bytes_left_ff == LEN_ONE)
      |=> !in_payload_ff && (header_index_ff == '0))
      else $error("record did not end after last byte");

endmodule
